// ===== rtl/lpi_pkg.sv =====
// Shared types and constants for the line/plane intersection pipeline.
// No dependencies.
package lpi_pkg;

	typedef enum logic [1:0] {
		REG_PLANE_POINT = 2'd0,
		REG_PLANE_DIR_A = 2'd1,
		REG_PLANE_DIR_B = 2'd2
	} reg_idx_t;

	localparam int CFG_IDX_BITS = 2;

endpackage

// ===== rtl/lpi_det.sv =====
// Determinant front end: cofactors, then the four 3x3 determinants.
// Depends on lpi_pkg. Three register stages.
module lpi_det #(
	parameter int CB = 16,
	parameter int DW = 3 * CB + 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_v,
	input  logic signed [CB-1:0] px, py, pz, ux, uy, uz,
	input  logic signed [CB-1:0] qx, qy, qz, vx, vy, vz, wx, wy, wz,
	output logic                 out_v,
	output logic signed [DW-1:0] d_o, nl_o, nm_o, nn_o,
	output logic signed [CB-1:0] px_o, py_o, pz_o, ux_o, uy_o, uz_o
);
	import lpi_pkg::*;

	localparam int TW = CB + 1;
	localparam int MW = 2 * TW + 1;

	logic                 v_s1, v_s2, v_s3;
	logic signed [TW-1:0] t_s1 [3];
	logic signed [CB-1:0] p_s1 [3], u_s1 [3], v1_s1 [3], w1_s1 [3];
	logic signed [CB-1:0] p_s2 [3], u_s2 [3];
	logic signed [TW-1:0] t_s2 [3];
	logic signed [MW-1:0] cvw_s2 [3], ctw_s2 [3], ctv_s2 [3];
	logic signed [CB-1:0] p_s3 [3], u_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= px; p_s1[1] <= py; p_s1[2] <= pz;
			u_s1[0] <= ux; u_s1[1] <= uy; u_s1[2] <= uz;
			v1_s1[0] <= vx; v1_s1[1] <= vy; v1_s1[2] <= vz;
			w1_s1[0] <= wx; w1_s1[1] <= wy; w1_s1[2] <= wz;
			t_s1[0] <= TW'(qx) - TW'(px);
			t_s1[1] <= TW'(qy) - TW'(py);
			t_s1[2] <= TW'(qz) - TW'(pz);
		end
	end

	// cofactors of the column pairs; signs of -v, -w folded in below
	function automatic logic signed [MW-1:0] cr(input logic signed [TW-1:0] a1, a2, b1, b2);
		return MW'(a1 * b2) - MW'(a2 * b1);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= p_s1;
			u_s2 <= u_s1;
			t_s2 <= t_s1;
			for (int i = 0; i < 3; i++) begin
				cvw_s2[i] <= cr(TW'(v1_s1[(i+1)%3]), TW'(v1_s1[(i+2)%3]),
					TW'(w1_s1[(i+1)%3]), TW'(w1_s1[(i+2)%3]));
				ctw_s2[i] <= cr(t_s1[(i+1)%3], t_s1[(i+2)%3],
					TW'(w1_s1[(i+1)%3]), TW'(w1_s1[(i+2)%3]));
				ctv_s2[i] <= cr(t_s1[(i+1)%3], t_s1[(i+2)%3],
					TW'(v1_s1[(i+1)%3]), TW'(v1_s1[(i+2)%3]));
			end
		end
	end

	// det(a,b,c) = a . (b x c); cross products in cyclic form
	function automatic logic signed [DW-1:0] dot(input logic signed [TW-1:0] a0, a1, a2,
		input logic signed [MW-1:0] c0, c1, c2);
		return DW'(a0 * c0) + DW'(a1 * c1) + DW'(a2 * c2);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3 <= p_s2;
			u_s3 <= u_s2;
			// D = u.(v x w)
			d_o  <= dot(TW'(u_s2[0]), TW'(u_s2[1]), TW'(u_s2[2]),
				cvw_s2[0], cvw_s2[1], cvw_s2[2]);
			// lambda num = t.(v x w)
			nl_o <= dot(t_s2[0], t_s2[1], t_s2[2], cvw_s2[0], cvw_s2[1], cvw_s2[2]);
			// mu num = det(u,t,-w) = -u.(t x w)
			nm_o <= -dot(TW'(u_s2[0]), TW'(u_s2[1]), TW'(u_s2[2]),
				ctw_s2[0], ctw_s2[1], ctw_s2[2]);
			// nu num = det(u,-v,t) = -u.(v x t) = u.(t x v)
			nn_o <= dot(TW'(u_s2[0]), TW'(u_s2[1]), TW'(u_s2[2]),
				ctv_s2[0], ctv_s2[1], ctv_s2[2]);
		end
	end

	assign out_v = v_s3;
	assign px_o = p_s3[0]; assign py_o = p_s3[1]; assign pz_o = p_s3[2];
	assign ux_o = u_s3[0]; assign uy_o = u_s3[1]; assign uz_o = u_s3[2];

endmodule

// ===== rtl/lpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, round and saturate.
// Depends on lpi_pkg. Produces signed Q.FB quotient clamped to 32 bits.
module lpi_div #(
	parameter int NW = 51,
	parameter int FB = 16
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic signed [31:0]   quo,
	output logic                 sat
);
	import lpi_pkg::*;

	// quotient magnitude bits: 32 integer-and-fraction bits plus one round bit
	localparam int QB = 33;
	localparam int NS = QB;
	localparam int RW = NW + 1;

	logic [NW-1:0] un, ud;
	logic          neg;
	logic [NW-1:0] n_sh;
	logic          big;

	assign un  = num[NW-1] ? NW'(-num) : NW'(num);
	assign ud  = den[NW-1] ? NW'(-den) : NW'(den);
	assign neg = num[NW-1] ^ den[NW-1];
	// integer quotient too big if un >= ud << (32-FB)
	assign big = ({(32-FB)'(0), un} >> (32 - FB)) >= {(32-FB)'(0), ud};
	assign n_sh = un;

	logic [RW-1:0] r_s   [NS+1];
	logic [QB-1:0] nb_s  [NS+1];
	logic [NW-1:0] d_s   [NS+1];
	logic [QB-1:0] q_s   [NS+1];
	logic          ng_s  [NS+1];
	logic          bg_s  [NS+1];

	// stage 0: the dividend's top bits seed the remainder; the low 32-FB bits
	// and FB+1 zero fraction bits are brought down by the stages below
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s[0]  <= RW'(n_sh >> (32 - FB));
			nb_s[0] <= {n_sh[31-FB:0], (FB+1)'(0)};
			d_s[0]  <= ud;
			q_s[0]  <= '0;
			ng_s[0] <= neg;
			bg_s[0] <= big;
		end
	end

	// The value un*2^(FB+1)/ud, truncated, has at most QB significant bits when
	// not big, so the seeded remainder is already below ud.
	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_st
			logic [RW-1:0] rt;
			logic [RW-1:0] rd;
			always_comb begin
				rt = {r_s[g][RW-2:0], nb_s[g][QB-1]};
				rd = rt - RW'(d_s[g]);
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					nb_s[g+1] <= nb_s[g] << 1;
					d_s[g+1]  <= d_s[g];
					ng_s[g+1] <= ng_s[g];
					bg_s[g+1] <= bg_s[g];
					if (!rd[RW-1]) begin
						r_s[g+1] <= rd;
						q_s[g+1] <= {q_s[g][QB-2:0], 1'b1};
					end else begin
						r_s[g+1] <= rt;
						q_s[g+1] <= {q_s[g][QB-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	logic [QB:0] mag;
	logic        s_n;
	always_comb begin
		mag = {1'b0, q_s[NS]} + (QB+1)'(1);
		mag = mag >> 1;
		if (bg_s[NS]) mag = (QB+1)'(1) << 32;
		s_n = 1'b0;
		if (ng_s[NS]) begin
			if (mag > ((QB+1)'(1) << 31)) s_n = 1'b1;
		end else if (mag > (QB+1)'(32'h7fffffff)) s_n = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat <= s_n;
			if (ng_s[NS]) quo <= s_n ? 32'sh80000000 : -$signed(mag[31:0]);
			else quo <= s_n ? 32'sh7fffffff : $signed(mag[31:0]);
		end
	end

endmodule

// ===== rtl/line_plane_intersect.sv =====
// Line/plane intersection by Cramer's rule: one line per cycle, fully pipelined.
// Pipeline: determinant front end, then the dividers, then the hit-point products, then the output register.
// Throughput one transfer per cycle; a stall at the output freezes every stage.
// Reset clears all valid bits and the three plane registers to zero.
// Depends on lpi_pkg, lpi_det, lpi_div.
module line_plane_intersect #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpi_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [3*COORD_BITS-1:0]              cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_BITS-1:0]         line_px, line_py, line_pz,
	input  logic signed [COORD_BITS-1:0]         line_ux, line_uy, line_uz,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [31:0]                   hit_x, hit_y, hit_z,
	output logic signed [31:0]                   line_param,
	output logic signed [31:0]                   plane_param_a, plane_param_b,
	output logic                                 is_parallel,
	output logic                                 did_saturate
);
	import lpi_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = 3 * CB + 3;
	localparam int DL = 35;
	localparam int HW = 32 + CB + 2;

	logic [3*CB-1:0] pp_q, pa_q, pb_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q <= '0; pa_q <= '0; pb_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_PLANE_POINT: pp_q <= cfg_data;
				REG_PLANE_DIR_A: pa_q <= cfg_data;
				REG_PLANE_DIR_B: pb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	logic dv;
	logic signed [DW-1:0] dd, nl, nm, nn;
	logic signed [CB-1:0] px3, py3, pz3, ux3, uy3, uz3;

	lpi_det #(.CB(CB), .DW(DW)) u_det (
		.clk, .arst_n, .adv, .in_v(in_valid),
		.px(line_px), .py(line_py), .pz(line_pz),
		.ux(line_ux), .uy(line_uy), .uz(line_uz),
		.qx(pp_q[CB-1:0]), .qy(pp_q[2*CB-1:CB]), .qz(pp_q[3*CB-1:2*CB]),
		.vx(pa_q[CB-1:0]), .vy(pa_q[2*CB-1:CB]), .vz(pa_q[3*CB-1:2*CB]),
		.wx(pb_q[CB-1:0]), .wy(pb_q[2*CB-1:CB]), .wz(pb_q[3*CB-1:2*CB]),
		.out_v(dv), .d_o(dd), .nl_o(nl), .nm_o(nm), .nn_o(nn),
		.px_o(px3), .py_o(py3), .pz_o(pz3), .ux_o(ux3), .uy_o(uy3), .uz_o(uz3)
	);

	logic signed [DW-1:0] den_safe;
	assign den_safe = (dd == '0) ? DW'(1) : dd;

	logic signed [31:0] lam, mu, nu;
	logic sl, sm, sn;

	lpi_div #(.NW(DW), .FB(FRAC_BITS)) u_dl (.clk, .adv, .num(nl), .den(den_safe),
		.quo(lam), .sat(sl));
	lpi_div #(.NW(DW), .FB(FRAC_BITS)) u_dm (.clk, .adv, .num(nm), .den(den_safe),
		.quo(mu), .sat(sm));
	lpi_div #(.NW(DW), .FB(FRAC_BITS)) u_dn (.clk, .adv, .num(nn), .den(den_safe),
		.quo(nu), .sat(sn));

	// delay line for side data while the dividers work
	logic                 dv_q  [DL];
	logic                 par_q [DL];
	logic signed [CB-1:0] pd_q  [DL][3];
	logic signed [CB-1:0] ud_q  [DL][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DL; i++) dv_q[i] <= 1'b0;
		end else if (adv) begin
			dv_q[0] <= dv;
			for (int i = 1; i < DL; i++) dv_q[i] <= dv_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			par_q[0] <= (dd == '0);
			pd_q[0][0] <= px3; pd_q[0][1] <= py3; pd_q[0][2] <= pz3;
			ud_q[0][0] <= ux3; ud_q[0][1] <= uy3; ud_q[0][2] <= uz3;
			for (int i = 1; i < DL; i++) begin
				par_q[i] <= par_q[i-1];
				pd_q[i]  <= pd_q[i-1];
				ud_q[i]  <= ud_q[i-1];
			end
		end
	end

	// hit stage 1: products
	logic                 v_s1, par_s1, sat_s1;
	logic signed [HW-1:0] prod_s1 [3];
	logic signed [CB-1:0] p_s1 [3];
	logic signed [31:0]   lam_s1, mu_s1, nu_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= dv_q[DL-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			par_s1 <= par_q[DL-1];
			sat_s1 <= sl | sm | sn;
			lam_s1 <= lam; mu_s1 <= mu; nu_s1 <= nu;
			p_s1 <= pd_q[DL-1];
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= HW'(lam) * HW'(ud_q[DL-1][i]);
		end
	end

	logic signed [HW-1:0] hs [3];
	logic [2:0] hsat;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hs[i] = prod_s1[i] + (HW'(p_s1[i]) <<< FRAC_BITS);
			hsat[i] = (hs[i] > HW'(32'sh7fffffff)) || (hs[i] < -(HW'(1) <<< 31));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s1;
	end

	function automatic logic signed [31:0] clampw(input logic signed [HW-1:0] x);
		if (x > HW'(32'sh7fffffff)) return 32'sh7fffffff;
		if (x < -(HW'(1) <<< 31)) return 32'sh80000000;
		return x[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			is_parallel <= par_s1;
			if (par_s1) begin
				hit_x <= '0; hit_y <= '0; hit_z <= '0;
				line_param <= '0; plane_param_a <= '0; plane_param_b <= '0;
				did_saturate <= 1'b0;
			end else begin
				hit_x <= clampw(hs[0]);
				hit_y <= clampw(hs[1]);
				hit_z <= clampw(hs[2]);
				line_param <= lam_s1;
				plane_param_a <= mu_s1;
				plane_param_b <= nu_s1;
				did_saturate <= sat_s1 | (|hsat);
			end
		end
	end

endmodule

// ===== rtl/lpi_chk.sv =====
// Port-level checker for line_plane_intersect, bound to the top level.
// Depends on nothing but the top level's ports.
module lpi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_parallel,
	input logic        did_saturate,
	input logic [31:0] hit_x,
	input logic [31:0] line_param
);
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready low with empty output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_x))
		else $error("stalled result changed");
	a_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_parallel |-> !did_saturate && line_param == 32'd0 && hit_x == 32'd0)
		else $error("parallel result not zero");
endmodule

bind line_plane_intersect lpi_chk u_lpi_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.is_parallel, .did_saturate, .hit_x, .line_param
);

// ===== tb/sv/line_plane_intersect_tb.sv =====
// Self-checking testbench for line_plane_intersect: drives lines against several
// plane settings and checks every transfer against a fixed-point Cramer's rule model.
// Depends on lpi_pkg and the line_plane_intersect RTL.
`timescale 1ns / 100ps

module line_plane_intersect_tb;
	import lpi_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [15:0] px, py, pz, ux, uy, uz;
	} line_t;

	typedef struct {
		logic signed [31:0] hx, hy, hz, lam, mu, nu;
		logic par, sat;
	} hit_t;

	typedef longint vec3_t [3];

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [47:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [15:0] line_px, line_py, line_pz, line_ux, line_uy, line_uz;
	logic out_valid, out_ready;
	logic signed [31:0] hit_x, hit_y, hit_z, line_param, plane_param_a, plane_param_b;
	logic is_parallel, did_saturate;

	logic [47:0] plane_q, plane_v, plane_w;
	hit_t expected_hits [$];
	int errors;
	int stall_cycles;
	bit idle_off;
	bit hold_req;

	line_plane_intersect i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.line_px(line_px), .line_py(line_py), .line_pz(line_pz),
		.line_ux(line_ux), .line_uy(line_uy), .line_uz(line_uz),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.line_param(line_param),
		.plane_param_a(plane_param_a), .plane_param_b(plane_param_b),
		.is_parallel(is_parallel), .did_saturate(did_saturate)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void unpack_vec(input logic [47:0] r, output vec3_t o);
		o[0] = longint'($signed(r[15:0]));
		o[1] = longint'($signed(r[31:16]));
		o[2] = longint'($signed(r[47:32]));
	endfunction

	function automatic longint det3(input vec3_t a, input vec3_t b, input vec3_t c);
		longint m0, m1, m2;
		m0 = b[1] * c[2] - b[2] * c[1];
		m1 = b[0] * c[2] - b[2] * c[0];
		m2 = b[0] * c[1] - b[1] * c[0];
		return a[0] * m0 - a[1] * m1 + a[2] * m2;
	endfunction

	function automatic longint fix_div(input longint n, input longint d, inout bit sat);
		bit neg;
		longint unsigned un, ud, qi, r, mag;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		qi = un / ud;
		r = un % ud;
		if (qi > 64'd65535) begin
			mag = 64'd1 << 32;
		end else begin
			mag = qi << 16;
			for (int i = 15; i >= 0; i--) begin
				r = r << 1;
				if (r >= ud) begin
					r = r - ud;
					mag = mag | (64'd1 << i);
				end
			end
			if ((r << 1) >= ud)
				mag = mag + 1;
		end
		if (neg) begin
			if (mag > (64'd1 << 31)) begin
				sat = 1'b1;
				return -longint'(64'd1 << 31);
			end
			return -longint'(mag);
		end
		if (mag > 64'h7fff_ffff) begin
			sat = 1'b1;
			return 64'h7fff_ffff;
		end
		return longint'(mag);
	endfunction

	function automatic longint clamp32(input longint x, inout bit sat);
		if (x > 64'sh7fff_ffff) begin
			sat = 1'b1;
			return 64'sh7fff_ffff;
		end
		if (x < -64'sh8000_0000) begin
			sat = 1'b1;
			return -64'sh8000_0000;
		end
		return x;
	endfunction

	function automatic hit_t predict_hit(input line_t l);
		vec3_t p, u, q, v, w, nv, nw, t;
		longint d, lam, mu, nu, h [3];
		bit sat;
		hit_t e;
		p[0] = l.px; p[1] = l.py; p[2] = l.pz;
		u[0] = l.ux; u[1] = l.uy; u[2] = l.uz;
		unpack_vec(plane_q, q);
		unpack_vec(plane_v, v);
		unpack_vec(plane_w, w);
		for (int i = 0; i < 3; i++) begin
			nv[i] = -v[i];
			nw[i] = -w[i];
			t[i] = q[i] - p[i];
		end
		e = '{default: 0};
		sat = 1'b0;
		d = det3(u, nv, nw);
		if (d == 0) begin
			e.par = 1'b1;
			return e;
		end
		lam = fix_div(det3(t, nv, nw), d, sat);
		mu = fix_div(det3(u, t, nw), d, sat);
		nu = fix_div(det3(u, nv, t), d, sat);
		for (int i = 0; i < 3; i++)
			h[i] = clamp32(p[i] * 65536 + lam * u[i], sat);
		e.hx = h[0][31:0];
		e.hy = h[1][31:0];
		e.hz = h[2][31:0];
		e.lam = lam[31:0];
		e.mu = mu[31:0];
		e.nu = nu[31:0];
		e.sat = sat;
		return e;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint exp);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
		errors++;
	endtask

	// result checker and receiver idling
	initial begin
		hit_t e;
		int hold_left;
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected transfer", 1, 0);
				end else begin
					e = expected_hits.pop_front();
					if (hit_x !== e.hx) report_mismatch("hit_x", hit_x, e.hx);
					if (hit_y !== e.hy) report_mismatch("hit_y", hit_y, e.hy);
					if (hit_z !== e.hz) report_mismatch("hit_z", hit_z, e.hz);
					if (line_param !== e.lam) report_mismatch("line_param", line_param, e.lam);
					if (plane_param_a !== e.mu)
						report_mismatch("plane_param_a", plane_param_a, e.mu);
					if (plane_param_b !== e.nu)
						report_mismatch("plane_param_b", plane_param_b, e.nu);
					if (is_parallel !== e.par) report_mismatch("is_parallel", is_parallel, e.par);
					if (did_saturate !== e.sat)
						report_mismatch("did_saturate", did_saturate, e.sat);
				end
			end
			if (hold_req && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					hold_req = 1'b0;
				out_ready <= 1'b0;
			end else begin
				out_ready <= idle_off || ($urandom_range(99) >= 13);
			end
		end
	end

	// watchdog
	initial begin
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [47:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PLANE_POINT: plane_q = data;
			REG_PLANE_DIR_A: plane_v = data;
			REG_PLANE_DIR_B: plane_w = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_plane(input logic [47:0] q, input logic [47:0] v, input logic [47:0] w);
		write_reg(REG_PLANE_POINT, q);
		write_reg(REG_PLANE_DIR_A, v);
		write_reg(REG_PLANE_DIR_B, w);
	endtask

	task automatic send_line(input line_t l);
		if (!idle_off && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		line_px <= l.px; line_py <= l.py; line_pz <= l.pz;
		line_ux <= l.ux; line_uy <= l.uy; line_uz <= l.uz;
		do @(posedge clk); while (!in_ready);
		expected_hits.push_back(predict_hit(l));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord(input int mode);
		case (mode)
			0: return 16'($urandom_range(65535));
			1: return 16'($signed($urandom_range(16)) - 8);
			2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			default: return 16'($signed($urandom_range(512)) - 256);
		endcase
	endfunction

	function automatic logic [47:0] rand_vec(input int mode);
		return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
	endfunction

	function automatic line_t rand_line;
		line_t l;
		int m;
		m = $urandom_range(3);
		l.px = rand_coord(m); l.py = rand_coord(m); l.pz = rand_coord(m);
		m = $urandom_range(3);
		l.ux = rand_coord(m); l.uy = rand_coord(m); l.uz = rand_coord(m);
		if ($urandom_range(19) == 0) begin
			l.ux = 0; l.uy = 0; l.uz = 0;
		end
		return l;
	endfunction

	function automatic line_t mk(input int px, py, pz, ux, uy, uz);
		line_t l;
		l.px = 16'(px); l.py = 16'(py); l.pz = 16'(pz);
		l.ux = 16'(ux); l.uy = 16'(uy); l.uz = 16'(uz);
		return l;
	endfunction

	task automatic test_reset_plane;
		send_line(mk(1, 2, 3, 4, 5, 6));
		send_line(mk(-32768, 32767, 0, 32767, -32768, 1));
		drain();
	endtask

	task automatic test_directed;
		set_plane({16'sd0, 16'sd0, 16'sd0}, {16'sd0, 16'sd0, 16'sd1}, {16'sd0, 16'sd1, 16'sd0});
		send_line(mk(0, 0, 5, 0, 0, -1));
		send_line(mk(3, -4, 10, 1, 1, -2));
		send_line(mk(1, 1, 1, 1, 0, 0));
		send_line(mk(1, 1, 1, 0, 1, 0));
		send_line(mk(0, 0, 0, 0, 0, 0));
		send_line(mk(0, 0, 1, 0, 0, 3));
		send_line(mk(0, 0, 1, 0, 0, -3));
		send_line(mk(0, 0, 1, 0, 0, 32767));
		send_line(mk(-32768, -32768, -32768, 1, 1, 1));
		send_line(mk(32767, 32767, 32767, -32768, -32768, -32768));
		send_line(mk(32767, 32767, 32767, 32767, 32767, 1));
		send_line(mk(-32768, 32767, -32768, -1, 1, -1));
		send_line(mk(0, 0, 32767, 1, 0, -1));
		send_line(mk(7, 7, -1, 0, 0, 2));
		drain();
		set_plane({16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h8000, 16'h7fff},
			{16'h7fff, 16'h8000, 16'h8000});
		send_line(mk(-32768, -32768, -32768, 32767, 32767, 32767));
		send_line(mk(32767, -32768, 32767, 1, -1, 1));
		send_line(mk(0, 0, 0, -32768, 0, 0));
		drain();
	endtask

	task automatic test_unused_index;
		write_reg(REG_UNUSED, 48'h1234_5678_9abc);
		send_line(mk(1, 2, 3, 1, 1, 1));
		drain();
	endtask

	task automatic test_random(input int phases, input int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			case (ph % 4)
				0: set_plane(rand_vec(1), rand_vec(1), rand_vec(1));
				1: set_plane(rand_vec(3), rand_vec(3), rand_vec(0));
				2: set_plane(rand_vec(0), rand_vec(0), rand_vec(0));
				default: set_plane(rand_vec(2), rand_vec(1), rand_vec(2));
			endcase
			idle_off = (ph == 2);
			for (int i = 0; i < per_phase; i++)
				send_line(rand_line());
			drain();
		end
		idle_off = 1'b0;
	endtask

	task automatic test_backpressure;
		set_plane(rand_vec(3), rand_vec(3), rand_vec(3));
		hold_req = 1'b1;
		for (int i = 0; i < 100; i++)
			send_line(rand_line());
		drain();
	endtask

	initial begin
		errors = 0;
		idle_off = 1'b0;
		hold_req = 1'b0;
		plane_q = '0;
		plane_v = '0;
		plane_w = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_PLANE_POINT;
		cfg_data = '0;
		in_valid = 1'b0;
		line_px = '0; line_py = '0; line_pz = '0;
		line_ux = '0; line_uy = '0; line_uz = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_plane();
		test_directed();
		test_unused_index();
		test_backpressure();
		test_random(8, 100);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lpi_pkg.sv
rtl/lpi_det.sv
rtl/lpi_div.sv
rtl/line_plane_intersect.sv
rtl/lpi_chk.sv
tb/sv/line_plane_intersect_tb.sv
